### rtl/core/ssq_pkg.sv
// Shared types, constants and coil table for the stepper speed sequencer.
package ssq_pkg;

  localparam int ADC_BITS   = 10;
  localparam int TIMER_BITS = 16;
  localparam int STEP_BITS  = 12;
  localparam int REG_BITS   = 16;
  localparam int COIL_BITS  = 4;
  localparam int CFG_IDX_BITS = 8;

  localparam int PROD_BITS = ADC_BITS + REG_BITS;
  localparam int SUM_BITS  = REG_BITS + 1;
  localparam int PER_BITS  = (TIMER_BITS > SUM_BITS) ? TIMER_BITS : SUM_BITS;

  localparam logic [TIMER_BITS-1:0] TIMER_MAX = {TIMER_BITS{1'b1}};

  localparam logic [STEP_BITS-1:0]  TOTAL_STEPS_RST = STEP_BITS'(200);
  localparam logic [REG_BITS-1:0]   PERIOD_MIN_RST  = REG_BITS'(499);
  localparam logic [REG_BITS-1:0]   PERIOD_SPAN_RST = REG_BITS'(4500);
  localparam logic [ADC_BITS-1:0]   HYSTERESIS_RST  = ADC_BITS'(1);
  localparam logic [TIMER_BITS-1:0] PERIOD_RST      = TIMER_BITS'(499);

  typedef enum logic [1:0] {
    CMD_TICK    = 2'd0,
    CMD_SAMPLE  = 2'd1,
    CMD_RUN     = 2'd2,
    CMD_REVERSE = 2'd3
  } cmd_e;

  typedef enum logic [CFG_IDX_BITS-1:0] {
    REG_TOTAL_STEPS = 8'd0,
    REG_PERIOD_MIN  = 8'd1,
    REG_PERIOD_SPAN = 8'd2,
    REG_HYSTERESIS  = 8'd3
  } reg_idx_e;

  typedef struct packed {
    logic                  update;
    logic [TIMER_BITS-1:0] period;
  } speed_upd_t;

  typedef struct packed {
    logic [COIL_BITS-1:0] coil_pattern;
    logic                 step_taken;
    logic [STEP_BITS-1:0] steps_remaining;
    logic [REG_BITS-1:0]  step_period;
    logic                 is_running;
  } result_t;

  function automatic logic [COIL_BITS-1:0] coil_for_phase(input logic [1:0] ph);
    logic [COIL_BITS-1:0] pat;
    unique case (ph)
      2'd0: pat = 4'h5;
      2'd1: pat = 4'h6;
      2'd2: pat = 4'hA;
      2'd3: pat = 4'h9;
      default: pat = 4'h5;
    endcase
    return pat;
  endfunction

endpackage

### rtl/core/ssq_in_if.sv
// Input command channel interface.
interface ssq_in_if;
  import ssq_pkg::*;
  logic                valid;
  logic                ready;
  logic [1:0]          command;
  logic [ADC_BITS-1:0] adc_sample;
  modport source (output valid, output command, output adc_sample, input ready);
  modport sink (input valid, input command, input adc_sample, output ready);
endinterface

### rtl/core/ssq_out_if.sv
// Result channel interface.
interface ssq_out_if;
  import ssq_pkg::*;
  logic                 valid;
  logic                 ready;
  logic [COIL_BITS-1:0] coil_pattern;
  logic                 step_taken;
  logic [STEP_BITS-1:0] steps_remaining;
  logic [REG_BITS-1:0]  step_period;
  logic                 is_running;
  modport source (output valid, output coil_pattern, output step_taken,
                  output steps_remaining, output step_period, output is_running,
                  input ready);
  modport sink (input valid, input coil_pattern, input step_taken,
                input steps_remaining, input step_period, input is_running,
                output ready);
endinterface

### rtl/core/ssq_cfg_if.sv
// Configuration write channel interface.
interface ssq_cfg_if;
  import ssq_pkg::*;
  logic                    valid;
  logic                    ready;
  logic [CFG_IDX_BITS-1:0] index;
  logic [REG_BITS-1:0]     data;
  modport source (output valid, output index, output data, input ready);
  modport sink (input valid, input index, input data, output ready);
endinterface

### rtl/core/ssq_speed_unit.sv
// Hysteresis check and saturated compare period from a potentiometer sample.
module ssq_speed_unit
  import ssq_pkg::*;
(
  input  logic [ADC_BITS-1:0] sample_i,
  input  logic [ADC_BITS-1:0] last_sample_i,
  input  logic [ADC_BITS-1:0] hysteresis_i,
  input  logic [REG_BITS-1:0] period_min_i,
  input  logic [REG_BITS-1:0] period_span_i,
  output speed_upd_t          upd_o
);

  logic [ADC_BITS-1:0]  diff;
  logic [PROD_BITS-1:0] prod;
  logic [SUM_BITS-1:0]  sum;
  logic [PER_BITS-1:0]  sum_ext;

  always_comb begin
    diff = (sample_i > last_sample_i) ? (sample_i - last_sample_i)
                                      : (last_sample_i - sample_i);
    prod = PROD_BITS'(sample_i) * PROD_BITS'(period_span_i);
    sum = SUM_BITS'(period_min_i) + SUM_BITS'(prod[PROD_BITS-1:ADC_BITS]);
    sum_ext = PER_BITS'(sum);
    upd_o.update = (diff > hysteresis_i);
    upd_o.period = (sum_ext > PER_BITS'(TIMER_MAX)) ? TIMER_MAX
                                                    : sum_ext[TIMER_BITS-1:0];
  end

endmodule

### rtl/core/stepper_speed_sequencer.sv
// Top level of the full-step stepper sequencer with potentiometer speed control.
// Results are registered into the output entry, or the buffer entry while it is held.
// Throughput: one command per cycle; a two-entry result buffer keeps input open while
// one result waits, and input stalls only when both entries are full.
// Reset clears the buffer and sets registers and motor state to their defaults,
// with the step remainder at total steps minus one.
module stepper_speed_sequencer
  import ssq_pkg::*;
(
  input  logic clk_i,
  input  logic rst_ni,
  ssq_in_if.sink    in_i,
  ssq_cfg_if.sink   cfg_i,
  ssq_out_if.source out_o
);

  logic [STEP_BITS-1:0]  total_steps_q;
  logic [REG_BITS-1:0]   period_min_q, period_span_q;
  logic [ADC_BITS-1:0]   hysteresis_q;

  logic [TIMER_BITS-1:0] tick_count_q, tick_count_d;
  logic [TIMER_BITS-1:0] compare_period_q, compare_period_d;
  logic [ADC_BITS-1:0]   last_sample_q, last_sample_d;
  logic [1:0]            phase_q, phase_d;
  logic                  reverse_q, reverse_d;
  logic                  run_q, run_d;
  logic [STEP_BITS-1:0]  steps_left_q, steps_left_d;
  logic [COIL_BITS-1:0]  coils_q, coils_d;
  logic                  stepped;

  logic    out_valid_q, out_valid_d, skid_valid_q, skid_valid_d;
  result_t out_q, out_d, skid_q, skid_d, result;
  logic    accept, out_taken;
  speed_upd_t speed_upd;
  cmd_e    cmd;

  assign cfg_i.ready = 1'b1;
  assign in_i.ready  = !skid_valid_q;
  assign accept      = in_i.valid && in_i.ready;
  assign out_taken   = out_valid_q && out_o.ready;
  assign cmd         = cmd_e'(in_i.command);

  ssq_speed_unit u_speed (
    .sample_i      (in_i.adc_sample),
    .last_sample_i (last_sample_q),
    .hysteresis_i  (hysteresis_q),
    .period_min_i  (period_min_q),
    .period_span_i (period_span_q),
    .upd_o         (speed_upd)
  );

  always_comb begin
    tick_count_d     = tick_count_q;
    compare_period_d = compare_period_q;
    last_sample_d    = last_sample_q;
    phase_d          = phase_q;
    reverse_d        = reverse_q;
    run_d            = run_q;
    steps_left_d     = steps_left_q;
    coils_d          = coils_q;
    stepped          = 1'b0;
    unique case (cmd)
      CMD_TICK: begin
        if (tick_count_q == compare_period_q) begin
          tick_count_d = '0;
          if (run_q && (steps_left_q != '0)) begin
            coils_d      = coil_for_phase(phase_q);
            phase_d      = reverse_q ? (phase_q - 2'd1) : (phase_q + 2'd1);
            steps_left_d = steps_left_q - STEP_BITS'(1);
            stepped      = 1'b1;
          end
        end else begin
          tick_count_d = tick_count_q + TIMER_BITS'(1);
        end
      end
      CMD_SAMPLE: begin
        if (speed_upd.update) begin
          last_sample_d    = in_i.adc_sample;
          compare_period_d = speed_upd.period;
          tick_count_d     = '0;
        end
      end
      CMD_RUN: begin
        run_d = !run_q;
      end
      CMD_REVERSE: begin
        reverse_d    = !reverse_q;
        steps_left_d = total_steps_q - steps_left_q - STEP_BITS'(1);
        phase_d      = 2'd0;
      end
      default: ;
    endcase
    result.coil_pattern    = coils_d;
    result.step_taken      = stepped;
    result.steps_remaining = steps_left_d;
    result.step_period     = compare_period_d[REG_BITS-1:0];
    result.is_running      = run_d;
  end

  always_comb begin
    out_valid_d  = out_valid_q;
    out_d        = out_q;
    skid_valid_d = skid_valid_q;
    skid_d       = skid_q;
    if (out_taken || !out_valid_q) begin
      if (skid_valid_q) begin
        out_valid_d  = 1'b1;
        out_d        = skid_q;
        skid_valid_d = 1'b0;
      end else begin
        out_valid_d = accept;
        out_d       = result;
      end
    end else if (accept) begin
      skid_valid_d = 1'b1;
      skid_d       = result;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      total_steps_q <= TOTAL_STEPS_RST;
      period_min_q  <= PERIOD_MIN_RST;
      period_span_q <= PERIOD_SPAN_RST;
      hysteresis_q  <= HYSTERESIS_RST;
    end else if (cfg_i.valid && cfg_i.ready) begin
      unique case (cfg_i.index)
        REG_TOTAL_STEPS: total_steps_q <= cfg_i.data[STEP_BITS-1:0];
        REG_PERIOD_MIN:  period_min_q  <= cfg_i.data;
        REG_PERIOD_SPAN: period_span_q <= cfg_i.data;
        REG_HYSTERESIS:  hysteresis_q  <= cfg_i.data[ADC_BITS-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tick_count_q     <= '0;
      compare_period_q <= PERIOD_RST;
      last_sample_q    <= '0;
      phase_q          <= 2'd0;
      reverse_q        <= 1'b0;
      run_q            <= 1'b0;
      steps_left_q     <= TOTAL_STEPS_RST - STEP_BITS'(1);
      coils_q          <= '0;
    end else if (accept) begin
      tick_count_q     <= tick_count_d;
      compare_period_q <= compare_period_d;
      last_sample_q    <= last_sample_d;
      phase_q          <= phase_d;
      reverse_q        <= reverse_d;
      run_q            <= run_d;
      steps_left_q     <= steps_left_d;
      coils_q          <= coils_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q  <= 1'b0;
      skid_valid_q <= 1'b0;
    end else begin
      out_valid_q  <= out_valid_d;
      skid_valid_q <= skid_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    out_q  <= out_d;
    skid_q <= skid_d;
  end

  assign out_o.valid           = out_valid_q;
  assign out_o.coil_pattern    = out_q.coil_pattern;
  assign out_o.step_taken      = out_q.step_taken;
  assign out_o.steps_remaining = out_q.steps_remaining;
  assign out_o.step_period     = out_q.step_period;
  assign out_o.is_running      = out_q.is_running;

  // The buffer entry behind the output is only occupied while the output holds a result.
  a_skid_behind_out: assert property (@(posedge clk_i) disable iff (!rst_ni)
    skid_valid_q |-> out_valid_q)
    else $error("result buffer holds an entry while output is empty");

  // A step is only reported while the motor is enabled.
  a_step_running: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_o.valid && out_o.step_taken) |-> out_o.is_running)
    else $error("step reported while stopped");

  // Each step consumes exactly one from the remainder.
  a_step_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (accept && stepped) |=> (steps_left_q == $past(steps_left_q) - STEP_BITS'(1)))
    else $error("step remainder not decremented by one");

endmodule

### tb/stepper_speed_sequencer_tb.sv
// Self-checking testbench for the stepper speed sequencer: directed and random commands.
`timescale 1ns / 100ps

module stepper_speed_sequencer_tb;
  import ssq_pkg::*;

  localparam logic [COIL_BITS-1:0] COIL_SEQ [4] = '{4'h5, 4'h6, 4'hA, 4'h9};

  logic clk;
  logic rst_n;

  ssq_in_if  in_ch ();
  ssq_cfg_if cfg_ch ();
  ssq_out_if out_ch ();

  stepper_speed_sequencer dut (
    .clk_i (clk),
    .rst_ni(rst_n),
    .in_i  (in_ch),
    .cfg_i (cfg_ch),
    .out_o (out_ch)
  );

  logic [STEP_BITS-1:0]  cfg_total = TOTAL_STEPS_RST;
  logic [REG_BITS-1:0]   cfg_pmin  = PERIOD_MIN_RST;
  logic [REG_BITS-1:0]   cfg_span  = PERIOD_SPAN_RST;
  logic [ADC_BITS-1:0]   cfg_hyst  = HYSTERESIS_RST;

  logic [TIMER_BITS-1:0] tick_cnt    = '0;
  logic [TIMER_BITS-1:0] cmp_period  = PERIOD_RST;
  logic [ADC_BITS-1:0]   last_smp    = '0;
  logic [1:0]            motor_phase = '0;
  logic                  motor_rev   = 1'b0;
  logic                  motor_run   = 1'b0;
  logic [STEP_BITS-1:0]  steps_left  = TOTAL_STEPS_RST - 1'b1;
  logic [COIL_BITS-1:0]  coil_drv    = '0;

  result_t expected_results [$];

  int errors      = 0;
  int n_commands  = 0;
  int n_results   = 0;
  int n_steps     = 0;
  int n_writes    = 0;
  int src_left    = 0;
  bit src_quiet   = 1'b0;
  int snk_left    = 0;
  bit snk_quiet   = 1'b0;

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  initial begin
    #5_000_000;
    $display("Timeout at %0t", $time);
    $display("CHECKS FAILED");
    $finish;
  end

  function automatic int draw_wait(inout int left, inout bit quiet);
    if (left == 0) begin
      quiet = ($urandom_range(0, 3) == 0);
      left  = $urandom_range(20, 60);
    end
    left--;
    return quiet ? 0 : $urandom_range(0, 18);
  endfunction

  function automatic result_t advance_motor(input cmd_e cmd, input logic [ADC_BITS-1:0] smp);
    result_t               r;
    logic [ADC_BITS-1:0]   diff;
    logic [PROD_BITS:0]    prod;
    logic [SUM_BITS-1:0]   sum;
    r.step_taken = 1'b0;
    case (cmd)
      CMD_TICK: begin
        if (tick_cnt == cmp_period) begin
          tick_cnt = '0;
          if (motor_run && steps_left != '0) begin
            coil_drv    = COIL_SEQ[motor_phase];
            motor_phase = motor_rev ? motor_phase - 2'd1 : motor_phase + 2'd1;
            steps_left  = steps_left - 1'b1;
            r.step_taken = 1'b1;
          end
        end else begin
          tick_cnt = tick_cnt + 1'b1;
        end
      end
      CMD_SAMPLE: begin
        diff = (smp > last_smp) ? smp - last_smp : last_smp - smp;
        if (diff > cfg_hyst) begin
          last_smp   = smp;
          prod       = (PROD_BITS+1)'(smp) * (PROD_BITS+1)'(cfg_span);
          sum        = SUM_BITS'(cfg_pmin) + SUM_BITS'(prod >> ADC_BITS);
          cmp_period = sum[SUM_BITS-1] ? TIMER_MAX : sum[TIMER_BITS-1:0];
          tick_cnt   = '0;
        end
      end
      CMD_RUN: motor_run = ~motor_run;
      CMD_REVERSE: begin
        motor_rev   = ~motor_rev;
        steps_left  = cfg_total - steps_left - 1'b1;
        motor_phase = 2'd0;
      end
      default: ;
    endcase
    r.coil_pattern    = coil_drv;
    r.steps_remaining = steps_left;
    r.step_period     = cmp_period;
    r.is_running      = motor_run;
    return r;
  endfunction

  task automatic send_cmd(input cmd_e cmd, input logic [ADC_BITS-1:0] smp);
    int      gap;
    result_t r;
    gap = draw_wait(src_left, src_quiet);
    @(negedge clk);
    if (gap > 0) begin
      in_ch.valid = 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_ch.valid      = 1'b1;
    in_ch.command    = cmd;
    in_ch.adc_sample = smp;
    do @(posedge clk); while (!in_ch.ready);
    r = advance_motor(cmd, smp);
    expected_results.push_back(r);
    n_commands++;
    if (r.step_taken) n_steps++;
  endtask

  task automatic drain();
    @(negedge clk);
    in_ch.valid = 1'b0;
    while (expected_results.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_reg(input logic [CFG_IDX_BITS-1:0] idx, input logic [REG_BITS-1:0] data);
    @(negedge clk);
    cfg_ch.valid = 1'b1;
    cfg_ch.index = idx;
    cfg_ch.data  = data;
    do @(posedge clk); while (!cfg_ch.ready);
    case (idx)
      REG_TOTAL_STEPS: cfg_total = data[STEP_BITS-1:0];
      REG_PERIOD_MIN:  cfg_pmin  = data;
      REG_PERIOD_SPAN: cfg_span  = data;
      REG_HYSTERESIS:  cfg_hyst  = data[ADC_BITS-1:0];
      default: ;
    endcase
    n_writes++;
    @(negedge clk);
    cfg_ch.valid = 1'b0;
  endtask

  task automatic check_field(input string name, input int unsigned exp_v, input int unsigned act_v);
    if (exp_v != act_v) begin
      errors++;
      $display("%0t: %s mismatch, expected %0h, actual %0h", $time, name, exp_v, act_v);
    end
  endtask

  initial begin
    result_t r;
    int      stall;
    out_ch.ready = 1'b0;
    wait (rst_n === 1'b1);
    forever begin
      stall = draw_wait(snk_left, snk_quiet);
      @(negedge clk);
      if (stall > 0) begin
        out_ch.ready = 1'b0;
        repeat (stall) @(negedge clk);
      end
      out_ch.ready = 1'b1;
      do @(posedge clk); while (!out_ch.valid);
      n_results++;
      if (expected_results.size() == 0) begin
        errors++;
        $display("%0t: result with no transaction pending, coils %0h steps %0h period %0h",
                 $time, out_ch.coil_pattern, out_ch.steps_remaining, out_ch.step_period);
      end else begin
        r = expected_results.pop_front();
        check_field("coil_pattern", 32'(r.coil_pattern), 32'(out_ch.coil_pattern));
        check_field("step_taken", 32'(r.step_taken), 32'(out_ch.step_taken));
        check_field("steps_remaining", 32'(r.steps_remaining),
                    32'(out_ch.steps_remaining));
        check_field("step_period", 32'(r.step_period), 32'(out_ch.step_period));
        check_field("is_running", 32'(r.is_running), 32'(out_ch.is_running));
      end
    end
  end

  task automatic test_reset_state();
    send_cmd(CMD_TICK, '0);
    send_cmd(CMD_TICK, 10'h3FF);
    send_cmd(CMD_SAMPLE, 10'd1);
    drain();
  endtask

  task automatic test_stepping();
    write_reg(REG_PERIOD_MIN, 16'd0);
    write_reg(REG_PERIOD_SPAN, 16'd0);
    send_cmd(CMD_SAMPLE, 10'h3FF);
    send_cmd(CMD_RUN, '0);
    repeat (6) send_cmd(CMD_TICK, '0);
    send_cmd(CMD_REVERSE, '0);
    repeat (3) send_cmd(CMD_TICK, '0);
    send_cmd(CMD_SAMPLE, 10'd0);
    drain();
  endtask

  task automatic test_period_saturation();
    write_reg(REG_PERIOD_MIN, 16'hFFFF);
    write_reg(REG_PERIOD_SPAN, 16'hFFFF);
    write_reg(REG_HYSTERESIS, 16'h03FF);
    send_cmd(CMD_SAMPLE, 10'h3FF);
    drain();
    write_reg(REG_HYSTERESIS, 16'h0000);
    write_reg(8'hA5, 16'hFFFF);
    send_cmd(CMD_SAMPLE, 10'h3FF);
    send_cmd(CMD_SAMPLE, 10'h3FF);
    send_cmd(CMD_SAMPLE, 10'h000);
    drain();
  endtask

  task automatic test_travel_limit();
    write_reg(REG_PERIOD_MIN, 16'd0);
    write_reg(REG_PERIOD_SPAN, 16'd0);
    write_reg(REG_TOTAL_STEPS, 16'd1);
    send_cmd(CMD_SAMPLE, 10'h155);
    send_cmd(CMD_REVERSE, '0);
    drain();
    write_reg(REG_TOTAL_STEPS, 16'(steps_left + 1'b1));
    send_cmd(CMD_REVERSE, '0);
    if (!motor_run) send_cmd(CMD_RUN, '0);
    send_cmd(CMD_TICK, '0);
    send_cmd(CMD_TICK, '0);
    drain();
  endtask

  task automatic test_random_phases();
    logic [STEP_BITS-1:0] ts;
    logic [REG_BITS-1:0]  pmin;
    logic [REG_BITS-1:0]  span;
    logic [ADC_BITS-1:0]  hyst;
    logic [ADC_BITS-1:0]  smp;
    int                   pick;
    for (int p = 0; p < 8; p++) begin
      ts   = (p == 0) ? 12'd1 : (p == 1) ? 12'hFFF : 12'($urandom_range(1, 64));
      pmin = (p == 2) ? 16'hFFFF : (p == 3) ? 16'd0 : 16'($urandom_range(0, 12));
      span = (p == 4) ? 16'hFFFF : (p == 3) ? 16'd0 : 16'($urandom_range(0, 80));
      hyst = (p == 5) ? 10'h3FF : (p == 6) ? 10'd0 : 10'($urandom_range(0, 40));
      if (p == 7) begin
        span = 16'($urandom());
        hyst = 10'($urandom());
      end
      write_reg(REG_TOTAL_STEPS, {4'($urandom_range(0, 15)), ts});
      write_reg(REG_PERIOD_MIN, pmin);
      write_reg(REG_PERIOD_SPAN, span);
      write_reg(REG_HYSTERESIS, {6'($urandom_range(0, 63)), hyst});
      for (int i = 0; i < 160; i++) begin
        pick = $urandom_range(0, 99);
        if (pick < 70) begin
          send_cmd(CMD_TICK, 10'($urandom()));
        end else if (pick < 85) begin
          if ($urandom_range(0, 2) == 0)
            smp = last_smp + 10'($urandom_range(0, 4)) - 10'd2;
          else
            smp = 10'($urandom());
          send_cmd(CMD_SAMPLE, smp);
        end else if (pick < 93) begin
          send_cmd(CMD_RUN, 10'($urandom()));
        end else begin
          send_cmd(CMD_REVERSE, 10'($urandom()));
        end
      end
      drain();
    end
  endtask

  initial begin
    rst_n             = 1'b0;
    in_ch.valid       = 1'b0;
    in_ch.command     = CMD_TICK;
    in_ch.adc_sample  = '0;
    cfg_ch.valid      = 1'b0;
    cfg_ch.index      = REG_TOTAL_STEPS;
    cfg_ch.data       = '0;
    repeat (4) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    test_reset_state();
    test_stepping();
    test_period_saturation();
    test_travel_limit();
    test_random_phases();
    drain();

    $display("Sent %0d commands and %0d register writes; compared %0d results, %0d of them steps.",
             n_commands, n_writes, n_results, n_steps);
    if (errors == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("%0d mismatches found.", errors);
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule
